// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/sld_pkg.sv
`default_nettype none
package sld_pkg;

  localparam int SAMPLE_W = 7;
  localparam int START_W  = 16;
  localparam int POS_W    = 17;
  localparam int LEVEL_W  = 6;
  localparam int DEPTH_W  = 7;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [START_W-1:0] interval_start;
    logic [POS_W-1:0]   interval_end;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } out_req_t;

  // push: every cell takes its upper neighbor, pop: every cell takes its lower neighbor
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/signal_level_interval_decomposer.sv
// Level stack is a row of MAX_LEVEL shift cells; the top entry always sits in cell 0.
// Intervals are registered on the output in the pop steps after a request is taken.
// A request is taken only in idle; levels are then popped or pushed one at a time,
// pops waiting for a free output slot, until the depth reaches the target.
// Reset (rst_n low, synchronous): stack depth and position are zero, output empty;
// cell contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module signal_level_interval_decomposer #(
  parameter int MAX_LEVEL  = 64,
  parameter int MAX_LENGTH = 65536
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  sld_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output sld_pkg::out_req_t out_data
);

  localparam int DW = sld_pkg::DEPTH_W;
  localparam int PW = sld_pkg::POS_W;
  localparam int SW = sld_pkg::START_W;
  localparam logic [DW-1:0] MAX_LEVEL_D = DW'(MAX_LEVEL);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]        state_r,   state_nxt;
  logic [DW-1:0]     depth_r,   depth_nxt;
  logic [DW-1:0]     tgt_r,     tgt_nxt;
  logic [PW-1:0]     pos_r,     pos_nxt;
  logic [PW-1:0]     end_r,     end_nxt;
  logic              ovld_r,    ovld_nxt;
  sld_pkg::out_req_t odata_r,   odata_nxt;

  sld_pkg::cell_ctl_t ctl;
  logic [SW-1:0]      cell_q [MAX_LEVEL];

  logic          in_fire;
  logic          slot_free;
  logic          pop_fire;
  logic          len_full;
  logic [DW-1:0] sat_val;
  logic [DW-1:0] depth_dec;
  logic [DW-1:0] depth_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !ovld_r || out_ready;
  assign pop_fire  = (state_r == ST_POP) && slot_free;
  assign len_full  = (32'(pos_r) >= 32'(MAX_LENGTH));
  assign sat_val   = (in_data.sample > MAX_LEVEL_D) ? MAX_LEVEL_D : in_data.sample;
  assign depth_dec = depth_r - DW'(1);
  assign depth_inc = depth_r + DW'(1);

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    tgt_nxt   = tgt_r;
    pos_nxt   = pos_r;
    end_nxt   = end_r;
    ovld_nxt  = ovld_r && !out_ready;
    odata_nxt = odata_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.action) begin
            tgt_nxt = '0;
            end_nxt = pos_r;
            pos_nxt = '0;
            if (depth_r != '0) begin
              state_nxt = ST_POP;
            end
          end else if (!len_full) begin
            tgt_nxt = sat_val;
            end_nxt = pos_r;
            pos_nxt = pos_r + PW'(1);
            if (depth_r > sat_val) begin
              state_nxt = ST_POP;
            end else if (depth_r < sat_val) begin
              state_nxt = ST_PUSH;
            end
          end
        end
      end
      ST_POP: begin
        if (slot_free) begin
          ctl.pop                  = 1'b1;
          depth_nxt                = depth_dec;
          ovld_nxt                 = 1'b1;
          odata_nxt.interval_start = cell_q[0];
          odata_nxt.interval_end   = end_r;
          odata_nxt.level          = depth_dec[sld_pkg::LEVEL_W-1:0];
          odata_nxt.last           = (depth_dec == tgt_r);
          if (depth_dec == tgt_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PUSH: begin
        ctl.push  = 1'b1;
        depth_nxt = depth_inc;
        if (depth_inc == tgt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      depth_r <= '0;
      pos_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r   <= tgt_nxt;
    end_r   <= end_nxt;
    odata_r <= odata_nxt;
  end

  for (genvar i = 0; i < MAX_LEVEL; i++) begin : g_cell
    logic [SW-1:0] prev_d;
    logic [SW-1:0] next_d;
    if (i == 0) begin : g_top
      assign prev_d = end_r[SW-1:0];
    end else begin : g_mid
      assign prev_d = cell_q[i-1];
    end
    if (i == MAX_LEVEL - 1) begin : g_bot
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_q[i+1];
    end
    sld_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_prev (prev_d),
      .from_next (next_d),
      .q         (cell_q[i])
    );
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;

  `SLD_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= MAX_LEVEL_D)
  `SLD_ASSERT_IMP(a_pop_nonempty, state_r == ST_POP, depth_r != '0)
  `SLD_ASSERT_IMP(a_push_below_max, state_r == ST_PUSH, depth_r < tgt_r)
  `SLD_ASSERT_NXT(a_last_ends_item, pop_fire && (depth_dec == tgt_r), state_r == ST_IDLE)
  `SLD_ASSERT_NXT(a_flush_clears_pos, in_fire && in_data.action, pos_r == '0)

endmodule
`default_nettype wire

// File: rtl/sld_cell.sv
`default_nettype none
module sld_cell (
  input  wire                              clk,
  input  sld_pkg::cell_ctl_t               ctl,
  input  wire  [sld_pkg::START_W-1:0]      from_prev,
  input  wire  [sld_pkg::START_W-1:0]      from_next,
  output logic [sld_pkg::START_W-1:0]      q
);

  logic [sld_pkg::START_W-1:0] q_r;
  logic [sld_pkg::START_W-1:0] q_nxt;

  always_comb begin
    priority if (ctl.push) begin
      q_nxt = from_prev;
    end else if (ctl.pop) begin
      q_nxt = from_next;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire
